FILE: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decoder mode, one-hot
  typedef enum logic [3:0] {
    MODE_WAIT = 4'b0001,
    MODE_BODY = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_t;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
  localparam logic [2:0] ERR_END_ESC   = 3'd1;
  localparam logic [2:0] ERR_END_HEX   = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
  localparam logic [2:0] ERR_UNTERM    = 3'd4;
  localparam logic [2:0] ERR_NONE      = 3'd0;

  // Characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // UTF-8 encoding
  localparam logic [15:0] CP_LIM1   = 16'h0080;
  localparam logic [15:0] CP_LIM2   = 16'h0800;
  localparam logic [7:0]  UTF8_CONT = 8'h80;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_MASK6 = 8'h3F;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
  } result_t;

  // Results caused by one item; res[0] goes out first
  typedef struct packed {
    logic [1:0]           cnt;
    result_t [MAX_RES-1:0] res;
  } dec_res_t;

endpackage

FILE: src/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels for text bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output result_kind,
                  output error_code, output last, input ready);
  modport sink   (input valid, input out_byte, input result_kind,
                  input error_code, input last, output ready);
endinterface

FILE: src/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Decode state and per-byte decode logic; yields up to three results.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,       // item in input register consumed
  input  logic [7:0] text_byte,
  input  logic       text_end,
  output dec_res_t   dec
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic        stop_r, stop_nxt;

  logic        dig_vld;
  logic [3:0]  dig_val;
  logic [15:0] cp_acc;

  always_comb begin
    dig_vld = 1'b1;
    dig_val = 4'd0;
    if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
      dig_val = text_byte[3:0];
    end else if ((text_byte >= 8'h41 && text_byte <= 8'h46) ||
                 (text_byte >= 8'h61 && text_byte <= 8'h66)) begin
      dig_val = text_byte[3:0] + 4'd9;
    end else begin
      dig_vld = 1'b0;
    end
  end

  assign cp_acc = (!stop_r && dig_vld) ? {cp_r[11:0], dig_val} : cp_r;

  always_comb begin
    mode_nxt = mode_r;
    cp_nxt   = cp_r;
    hcnt_nxt = hcnt_r;
    stop_nxt = stop_r;
    dec      = '0;
    case (mode_r)
      MODE_BODY: begin
        if (text_end) begin
          dec.cnt    = 2'd1;
          dec.res[0] = '{8'h00, KIND_ERR, ERR_UNTERM};
          mode_nxt   = MODE_WAIT;
        end else if (text_byte == CH_QUOTE) begin
          dec.cnt    = 2'd1;
          dec.res[0] = '{8'h00, KIND_DONE, ERR_NONE};
          mode_nxt   = MODE_WAIT;
        end else if (text_byte == CH_BSL) begin
          mode_nxt = MODE_ESC;
        end else begin
          dec.cnt    = 2'd1;
          dec.res[0] = '{text_byte, KIND_BYTE, ERR_NONE};
        end
      end
      MODE_ESC: begin
        if (text_end) begin
          dec.cnt    = 2'd1;
          dec.res[0] = '{8'h00, KIND_ERR, ERR_END_ESC};
          mode_nxt   = MODE_WAIT;
        end else begin
          dec.cnt  = 2'd1;
          mode_nxt = MODE_BODY;
          case (text_byte)
            CH_QUOTE: dec.res[0] = '{CH_QUOTE, KIND_BYTE, ERR_NONE};
            CH_BSL:   dec.res[0] = '{CH_BSL, KIND_BYTE, ERR_NONE};
            CH_SLASH: dec.res[0] = '{CH_SLASH, KIND_BYTE, ERR_NONE};
            CH_B:     dec.res[0] = '{8'h08, KIND_BYTE, ERR_NONE};
            CH_F:     dec.res[0] = '{8'h0C, KIND_BYTE, ERR_NONE};
            CH_N:     dec.res[0] = '{8'h0A, KIND_BYTE, ERR_NONE};
            CH_R:     dec.res[0] = '{8'h0D, KIND_BYTE, ERR_NONE};
            CH_T:     dec.res[0] = '{8'h09, KIND_BYTE, ERR_NONE};
            CH_U: begin
              dec.cnt  = 2'd0;
              cp_nxt   = '0;
              hcnt_nxt = '0;
              stop_nxt = 1'b0;
              mode_nxt = MODE_HEX;
            end
            default: begin
              dec.res[0] = '{8'h00, KIND_ERR, ERR_BAD_ESC};
              mode_nxt   = MODE_WAIT;
            end
          endcase
        end
      end
      MODE_HEX: begin
        if (text_end) begin
          dec.cnt    = 2'd1;
          dec.res[0] = '{8'h00, KIND_ERR, ERR_END_HEX};
          mode_nxt   = MODE_WAIT;
          cp_nxt     = '0;
          hcnt_nxt   = '0;
          stop_nxt   = 1'b0;
        end else if (hcnt_r == 2'd3) begin
          // fourth byte of the escape: emit the code point as UTF-8
          if (cp_acc < CP_LIM1) begin
            dec.cnt    = 2'd1;
            dec.res[0] = '{cp_acc[7:0], KIND_BYTE, ERR_NONE};
          end else if (cp_acc < CP_LIM2) begin
            dec.cnt    = 2'd2;
            dec.res[0] = '{UTF8_LEAD2 | {3'b000, cp_acc[10:6]}, KIND_BYTE, ERR_NONE};
            dec.res[1] = '{UTF8_CONT | (cp_acc[7:0] & UTF8_MASK6), KIND_BYTE, ERR_NONE};
          end else begin
            dec.cnt    = 2'd3;
            dec.res[0] = '{UTF8_LEAD3 | {4'b0000, cp_acc[15:12]}, KIND_BYTE, ERR_NONE};
            dec.res[1] = '{UTF8_CONT | (cp_acc[13:6] & UTF8_MASK6), KIND_BYTE, ERR_NONE};
            dec.res[2] = '{UTF8_CONT | (cp_acc[7:0] & UTF8_MASK6), KIND_BYTE, ERR_NONE};
          end
          cp_nxt   = '0;
          hcnt_nxt = '0;
          stop_nxt = 1'b0;
          mode_nxt = MODE_BODY;
        end else begin
          cp_nxt   = cp_acc;
          stop_nxt = stop_r | ~dig_vld;
          hcnt_nxt = hcnt_r + 2'd1;
        end
      end
      default: begin
        mode_nxt = MODE_WAIT;
        if (!text_end) begin
          if (text_byte == CH_QUOTE) begin
            cp_nxt   = '0;
            hcnt_nxt = '0;
            stop_nxt = 1'b0;
            mode_nxt = MODE_BODY;
          end else begin
            dec.cnt    = 2'd1;
            dec.res[0] = '{8'h00, KIND_ERR, ERR_NO_QUOTE};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WAIT;
      cp_r   <= '0;
      hcnt_r <= '0;
      stop_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      cp_r   <= cp_nxt;
      hcnt_r <= hcnt_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

FILE: src/jsu_out_buf.sv
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register: holds the results of one item, sends one per cycle while ready.
// ----------------------------------------------------------------------------
module jsu_out_buf import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,       // decoder item consumed this cycle
  input  dec_res_t dec,
  output logic     free,       // empty after this cycle's transfer
  jsu_out_if.source out_ch
);

  result_t [MAX_RES-1:0] res_r;
  logic [1:0]            cnt_r;
  logic                  pop;

  assign pop  = (cnt_r != 2'd0) && out_ch.ready;
  assign free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.out_byte    = res_r[0].data;
  assign out_ch.result_kind = res_r[0].kind;
  assign out_ch.error_code  = res_r[0].code;
  assign out_ch.last        = (cnt_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= dec.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= dec.res;
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_ch.ready)))
    else $error("result register overwritten with results pending");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0 && !out_ch.ready) |=> cnt_r == $past(cnt_r))
    else $error("pending result count changed during stall");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> dec.cnt <= 2'd3 && (dec.cnt != 2'd0 || dec.res == '0))
    else $error("decoder produced stray result data");

endmodule

FILE: src/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top
// JSON string unescaper with UTF-8 output of \u escapes.
// ----------------------------------------------------------------------------
// Takes one text byte per transfer and decodes a quoted JSON string: plain
// bytes pass through, simple escapes map to their byte, \uXXXX becomes one to
// three UTF-8 bytes, a closing quote gives a done result and malformed input
// gives an error result, after which the block waits for a new opening quote.
// While the output is ready, throughput is one input byte per cycle and the
// result register sends one result per cycle, so a \u escape that encodes to
// two or three bytes holds off the next input until its extra bytes are sent.
// An input byte passes the input register, then the result register.
// ----------------------------------------------------------------------------
module json_string_unescape_top import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  logic       in_acc;   // input transfer
  logic       fire;     // registered item decoded and moved to result register
  logic       buf_free;
  dec_res_t   dec;

  // The input register drains whenever the result register is empty after
  // this cycle's output transfer; single-result items flow every ready cycle.
  assign fire        = in_vld_r && buf_free;
  assign in_ch.ready = !in_vld_r || fire;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_ch.text_byte;
      in_end_r  <= in_ch.text_end;
    end
  end

  // Decode state machine and per-byte logic
  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .text_byte (in_byte_r),
    .text_end  (in_end_r),
    .dec       (dec)
  );

  // Result register; items with no result simply leave it empty
  jsu_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire),
    .dec    (dec),
    .free   (buf_free),
    .out_ch (out_ch)
  );

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_vld_r)
    else $error("accepted byte missing from input register");

  a_held_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !buf_free) |=> in_vld_r && in_byte_r == $past(in_byte_r)
                                && in_end_r == $past(in_end_r))
    else $error("input register lost a byte while result register busy");

endmodule
